// ----- design/lab_pkg.sv -----
// Shared types, widths and helper functions of the look-at basis core.
`default_nettype none
package lab_pkg;

  localparam int COORD_WIDTH = 32;
  localparam int RES_W       = 32;
  localparam int MAG_W       = 64;
  localparam int IDX_W       = $clog2(MAG_W);
  localparam int SM_W        = 31;
  localparam int ROOT_W      = MAG_W / 2;
  localparam int NUM_W       = 2 * SM_W;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [RES_W-1:0]       res_t;

  localparam res_t ONE_Q30 = res_t'(64'sd1 <<< (SM_W - 1));

  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } smvec_t;

  typedef struct packed {
    res_t [2:0] a;
    res_t [2:0] b;
    logic       deg;
  } side_t;

  typedef struct packed {
    coord_t eye_x;
    coord_t eye_y;
    coord_t eye_z;
    coord_t target_x;
    coord_t target_y;
    coord_t target_z;
    coord_t up_x;
    coord_t up_y;
    coord_t up_z;
  } in_t;

  typedef struct packed {
    res_t right_x;
    res_t right_y;
    res_t right_z;
    res_t upward_x;
    res_t upward_y;
    res_t upward_z;
    res_t forward_x;
    res_t forward_y;
    res_t forward_z;
    logic degenerate;
  } out_t;

  // Top set bit of v: {found, index}.
  function automatic logic [IDX_W:0] msb_find(input logic [MAG_W-1:0] v);
    logic [IDX_W:0] r;
    r = '0;
    for (int i = 0; i < MAG_W; i++) begin
      if (v[i]) r = {1'b1, IDX_W'(i)};
    end
    return r;
  endfunction

  // Shift so that a magnitude whose top bit sits at idx lands at bit SM_W-1.
  function automatic logic [SM_W-1:0] scale_mag(input logic [MAG_W-1:0] mag,
                                                 input logic [IDX_W-1:0] idx);
    logic [MAG_W-1:0] t;
    if (idx > IDX_W'(SM_W - 1)) t = mag >> (idx - IDX_W'(SM_W - 1));
    else                        t = mag << (IDX_W'(SM_W - 1) - idx);
    return t[SM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- design/lab_if.sv -----
// Valid/ready channel interfaces for input and result words.
`default_nettype none
interface lab_in_if;
  logic          valid;
  logic          ready;
  lab_pkg::in_t  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

interface lab_out_if;
  logic          valid;
  logic          ready;
  lab_pkg::out_t data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ----- design/lab_cross.sv -----
// Two-stage pipelined cross product, result in sign and magnitude.
`default_nettype none
module lab_cross (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   vld_i,
  input  lab_pkg::res_t [2:0]    a_i,
  input  lab_pkg::res_t [2:0]    b_i,
  input  lab_pkg::side_t         side_i,
  output logic                   vld_o,
  output lab_pkg::smvec_t        vec_o,
  output lab_pkg::side_t         side_o
);

  localparam int MAG_W = lab_pkg::MAG_W;

  logic                                   x1_vld_q;
  logic signed [lab_pkg::MAG_W-1:0]       prod_q [6];
  lab_pkg::side_t                         x1_side_q;
  logic signed [lab_pkg::MAG_W-1:0]       c_d [3];
  lab_pkg::smvec_t                        vec_d;
  logic                                   x2_vld_q;
  lab_pkg::smvec_t                        vec_q;
  lab_pkg::side_t                         x2_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_vld_q <= 1'b0;
      x2_vld_q <= 1'b0;
    end else if (adv_i) begin
      x1_vld_q <= vld_i;
      x2_vld_q <= x1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod_q[0] <= MAG_W'(a_i[1]) * MAG_W'(b_i[2]);
      prod_q[1] <= MAG_W'(a_i[2]) * MAG_W'(b_i[1]);
      prod_q[2] <= MAG_W'(a_i[2]) * MAG_W'(b_i[0]);
      prod_q[3] <= MAG_W'(a_i[0]) * MAG_W'(b_i[2]);
      prod_q[4] <= MAG_W'(a_i[0]) * MAG_W'(b_i[1]);
      prod_q[5] <= MAG_W'(a_i[1]) * MAG_W'(b_i[0]);
      x1_side_q <= side_i;
      vec_q     <= vec_d;
      x2_side_q <= x1_side_q;
    end
  end

  always_comb begin
    c_d[0] = prod_q[0] - prod_q[1];
    c_d[1] = prod_q[2] - prod_q[3];
    c_d[2] = prod_q[4] - prod_q[5];
    for (int i = 0; i < 3; i++) begin
      vec_d.neg[i] = c_d[i][lab_pkg::MAG_W-1];
      vec_d.mag[i] = c_d[i][lab_pkg::MAG_W-1] ? -c_d[i] : c_d[i];
    end
  end

  assign vld_o  = x2_vld_q;
  assign vec_o  = vec_q;
  assign side_o = x2_side_q;

endmodule
`default_nettype wire

// ----- design/lab_norm.sv -----
// Pipelined normalizer: scale, sum of squares, root and three quotients.
`default_nettype none
module lab_norm (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   adv_i,
  input  logic                   vld_i,
  input  lab_pkg::smvec_t        vec_i,
  input  lab_pkg::side_t         side_i,
  output logic                   vld_o,
  output lab_pkg::res_t [2:0]    vec_o,
  output lab_pkg::side_t         side_o
);

  localparam int SM_W   = lab_pkg::SM_W;
  localparam int ROOT_W = lab_pkg::ROOT_W;
  localparam int MAG_W  = lab_pkg::MAG_W;
  localparam int NUM_W  = lab_pkg::NUM_W;
  localparam int RES_W  = lab_pkg::RES_W;

  typedef struct packed {
    logic [2:0]           neg;
    logic                 zero;
    lab_pkg::side_t       side;
    logic [2:0][SM_W-1:0] m;
  } carry_t;

  typedef struct packed {
    carry_t            c;
    logic [MAG_W-1:0]  x;
    logic [ROOT_W-1:0] r;
    logic [ROOT_W+3:0] rem;
  } rt_t;

  typedef struct packed {
    carry_t                 c;
    logic [ROOT_W-1:0]      len;
    logic [2:0][SM_W-1:0]   nb;
    logic [2:0][ROOT_W-1:0] rem;
    logic [2:0][SM_W-1:0]   q;
  } dv_t;

  function automatic rt_t rt_step(input rt_t a);
    rt_t               o;
    logic [ROOT_W+3:0] rem2;
    logic [ROOT_W+3:0] trial;
    o     = a;
    rem2  = {a.rem[ROOT_W+1:0], a.x[MAG_W-1 -: 2]};
    trial = {2'b00, a.r, 2'b01};
    o.x   = a.x << 2;
    if (rem2 >= trial) begin
      o.rem = rem2 - trial;
      o.r   = {a.r[ROOT_W-2:0], 1'b1};
    end else begin
      o.rem = rem2;
      o.r   = {a.r[ROOT_W-2:0], 1'b0};
    end
    return o;
  endfunction

  function automatic dv_t dv_step(input dv_t a);
    dv_t             o;
    logic [ROOT_W:0] rem2;
    o = a;
    for (int i = 0; i < 3; i++) begin
      rem2    = {a.rem[i], a.nb[i][SM_W-1]};
      o.nb[i] = a.nb[i] << 1;
      if (rem2 >= {1'b0, a.len}) begin
        o.rem[i] = ROOT_W'(rem2 - {1'b0, a.len});
        o.q[i]   = {a.q[i][SM_W-2:0], 1'b1};
      end else begin
        o.rem[i] = rem2[ROOT_W-1:0];
        o.q[i]   = {a.q[i][SM_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

  // Stage 1: locate the top bit of the largest magnitude
  logic                         s1_vld_q;
  logic [lab_pkg::IDX_W:0]      s1_idx_q;
  lab_pkg::smvec_t              s1_vec_q;
  lab_pkg::side_t               s1_side_q;
  // Stage 2: scaled magnitudes
  logic                         s2_vld_q;
  carry_t                       s2_c_d, s2_c_q;
  // Stage 3: squares
  logic                         s3_vld_q;
  carry_t                       s3_c_q;
  logic [2:0][NUM_W-1:0]        s3_sq_q;
  // Root pipeline, entry 0 holds the sum
  rt_t                          rt_q   [ROOT_W+1];
  logic [ROOT_W:0]              rt_vld_q;
  rt_t                          rt0_d;
  // Quotient pipeline, entry 0 holds the set-up
  dv_t                          dv_q   [SM_W+1];
  logic [SM_W:0]                dv_vld_q;
  dv_t                          dv0_d;
  logic [2:0][NUM_W-1:0]        num_d;
  // Final stage
  logic                         f_vld_q;
  lab_pkg::res_t [2:0]          f_vec_d, f_vec_q;
  lab_pkg::side_t               f_side_d, f_side_q;

  always_comb begin
    s2_c_d.neg  = s1_vec_q.neg;
    s2_c_d.zero = ~s1_idx_q[lab_pkg::IDX_W];
    s2_c_d.side = s1_side_q;
    for (int i = 0; i < 3; i++) begin
      s2_c_d.m[i] = lab_pkg::scale_mag(s1_vec_q.mag[i],
                                       s1_idx_q[lab_pkg::IDX_W-1:0]);
    end
  end

  always_comb begin
    rt0_d     = '0;
    rt0_d.c   = s3_c_q;
    rt0_d.x   = MAG_W'(s3_sq_q[0]) + MAG_W'(s3_sq_q[1]) + MAG_W'(s3_sq_q[2]);
  end

  always_comb begin
    dv0_d     = '0;
    dv0_d.c   = rt_q[ROOT_W].c;
    dv0_d.len = rt_q[ROOT_W].r;
    for (int i = 0; i < 3; i++) begin
      num_d[i] = (NUM_W'(rt_q[ROOT_W].c.m[i]) << (SM_W - 1))
               + NUM_W'(rt_q[ROOT_W].r >> 1);
      dv0_d.rem[i] = ROOT_W'(num_d[i][NUM_W-1:SM_W]);
      dv0_d.nb[i]  = num_d[i][SM_W-1:0];
    end
  end

  always_comb begin
    f_side_d     = dv_q[SM_W].c.side;
    f_side_d.deg = dv_q[SM_W].c.side.deg | dv_q[SM_W].c.zero;
    for (int i = 0; i < 3; i++) begin
      if (dv_q[SM_W].c.zero)        f_vec_d[i] = '0;
      else if (dv_q[SM_W].c.neg[i]) f_vec_d[i] = -RES_W'(dv_q[SM_W].q[i]);
      else                          f_vec_d[i] = RES_W'(dv_q[SM_W].q[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
      rt_vld_q <= '0;
      dv_vld_q <= '0;
      f_vld_q  <= 1'b0;
    end else if (adv_i) begin
      s1_vld_q <= vld_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      rt_vld_q <= {rt_vld_q[ROOT_W-1:0], s3_vld_q};
      dv_vld_q <= {dv_vld_q[SM_W-1:0], rt_vld_q[ROOT_W]};
      f_vld_q  <= dv_vld_q[SM_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_idx_q  <= lab_pkg::msb_find(vec_i.mag[0] | vec_i.mag[1] | vec_i.mag[2]);
      s1_vec_q  <= vec_i;
      s1_side_q <= side_i;
      s2_c_q    <= s2_c_d;
      s3_c_q    <= s2_c_q;
      for (int i = 0; i < 3; i++) begin
        s3_sq_q[i] <= NUM_W'(s2_c_q.m[i]) * NUM_W'(s2_c_q.m[i]);
      end
      rt_q[0]   <= rt0_d;
      dv_q[0]   <= dv0_d;
      f_vec_q   <= f_vec_d;
      f_side_q  <= f_side_d;
    end
  end

  // One root bit per stage
  for (genvar k = 1; k <= ROOT_W; k++) begin : g_root
    always_ff @(posedge clk_i) begin
      if (adv_i) rt_q[k] <= rt_step(rt_q[k-1]);
    end
  end

  // One quotient bit per stage, three lanes side by side
  for (genvar k = 1; k <= SM_W; k++) begin : g_div
    always_ff @(posedge clk_i) begin
      if (adv_i) dv_q[k] <= dv_step(dv_q[k-1]);
    end
  end

  assign vld_o  = f_vld_q;
  assign vec_o  = f_vec_q;
  assign side_o = f_side_q;

endmodule
`default_nettype wire

// ----- design/look_at_basis_core.sv -----
// Top level of the look-at camera basis core.
//
//  channel  dir  word                                    handshake
//  in_i     in   eye, target, up (Q16.16, 9 x 32 bits)   valid/ready
//  out_o    out  right, upward, forward (Q2.30), flag    valid/ready
//
// Three preparation stages, three normalizers of 69
// stages each (scale, squares, 32-stage root, 31-stage divide) and two
// 2-stage cross products. One word enters every cycle unless out_o stalls.
// Reset clears only the valid bits; the data registers are not reset.
// A stall on out_o freezes the whole pipeline, so nothing is lost or repeated;
// the last normalizer stage acts as the output register.
`default_nettype none
module look_at_basis_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  lab_in_if.sink           in_i,
  lab_out_if.source        out_o
);

  localparam int CW    = lab_pkg::COORD_WIDTH;
  localparam int MAG_W = lab_pkg::MAG_W;
  localparam int RES_W = lab_pkg::RES_W;

  logic adv;

  // Advance everything whenever the output slot is free or being drained
  assign adv        = ~out_o.valid | out_o.ready;
  assign in_i.ready = adv;

  // Preparation: exact difference, magnitudes, then scale of the up vector
  lab_pkg::coord_t [2:0]     eye, tgt, upv;
  logic signed [CW:0]        diff [3];
  lab_pkg::smvec_t           d_d, u_d;

  logic                      p1_vld_q, p2_vld_q, p3_vld_q;
  lab_pkg::smvec_t           p1_d_q, p1_u_q, p2_d_q, p2_u_q, p3_d_q;
  logic [lab_pkg::IDX_W:0]   p2_idx_q;
  lab_pkg::res_t [2:0]       ups_d, p3_ups_q;
  logic [lab_pkg::SM_W-1:0]  ups_m [3];

  always_comb begin
    eye = {in_i.data.eye_z, in_i.data.eye_y, in_i.data.eye_x};
    tgt = {in_i.data.target_z, in_i.data.target_y, in_i.data.target_x};
    upv = {in_i.data.up_z, in_i.data.up_y, in_i.data.up_x};
    for (int i = 0; i < 3; i++) begin
      diff[i]     = {tgt[i][CW-1], tgt[i]} - {eye[i][CW-1], eye[i]};
      d_d.neg[i]  = diff[i][CW];
      d_d.mag[i]  = MAG_W'(diff[i][CW] ? -diff[i] : diff[i]);
      u_d.neg[i]  = upv[i][CW-1];
      // Widen before negating so the most negative coordinate keeps its magnitude
      u_d.mag[i]  = upv[i][CW-1] ? -MAG_W'(upv[i]) : MAG_W'(upv[i]);
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ups_m[i] = lab_pkg::scale_mag(p2_u_q.mag[i], p2_idx_q[lab_pkg::IDX_W-1:0]);
      ups_d[i] = p2_u_q.neg[i] ? -RES_W'(ups_m[i]) : RES_W'(ups_m[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
    end else if (adv) begin
      p1_vld_q <= in_i.valid;
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      p1_d_q   <= d_d;
      p1_u_q   <= u_d;
      p2_d_q   <= p1_d_q;
      p2_u_q   <= p1_u_q;
      p2_idx_q <= lab_pkg::msb_find(p1_u_q.mag[0] | p1_u_q.mag[1] | p1_u_q.mag[2]);
      p3_d_q   <= p2_d_q;
      p3_ups_q <= ups_d;
    end
  end

  // Forward axis; the scaled up vector rides along
  lab_pkg::side_t       n1_side_i, n1_side_o;
  logic                 n1_vld;
  lab_pkg::res_t [2:0]  fwd;

  assign n1_side_i = '{a: p3_ups_q, b: '0, deg: 1'b0};

  lab_norm u_norm_fwd (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (p3_vld_q),
    .vec_i  (p3_d_q),
    .side_i (n1_side_i),
    .vld_o  (n1_vld),
    .vec_o  (fwd),
    .side_o (n1_side_o)
  );

  // up x forward
  lab_pkg::side_t       c1_side_i, c1_side_o;
  logic                 c1_vld;
  lab_pkg::smvec_t      c1_vec;

  assign c1_side_i = '{a: fwd, b: '0, deg: n1_side_o.deg};

  lab_cross u_cross_rgt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (n1_vld),
    .a_i    (n1_side_o.a),
    .b_i    (fwd),
    .side_i (c1_side_i),
    .vld_o  (c1_vld),
    .vec_o  (c1_vec),
    .side_o (c1_side_o)
  );

  lab_pkg::side_t       n2_side_o;
  logic                 n2_vld;
  lab_pkg::res_t [2:0]  rgt;

  lab_norm u_norm_rgt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (c1_vld),
    .vec_i  (c1_vec),
    .side_i (c1_side_o),
    .vld_o  (n2_vld),
    .vec_o  (rgt),
    .side_o (n2_side_o)
  );

  // forward x right
  lab_pkg::side_t       c2_side_i, c2_side_o;
  logic                 c2_vld;
  lab_pkg::smvec_t      c2_vec;

  assign c2_side_i = '{a: n2_side_o.a, b: rgt, deg: n2_side_o.deg};

  lab_cross u_cross_upw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (n2_vld),
    .a_i    (n2_side_o.a),
    .b_i    (rgt),
    .side_i (c2_side_i),
    .vld_o  (c2_vld),
    .vec_o  (c2_vec),
    .side_o (c2_side_o)
  );

  lab_pkg::side_t       n3_side_o;
  logic                 n3_vld;
  lab_pkg::res_t [2:0]  upw;

  lab_norm u_norm_upw (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (c2_vld),
    .vec_i  (c2_vec),
    .side_i (c2_side_o),
    .vld_o  (n3_vld),
    .vec_o  (upw),
    .side_o (n3_side_o)
  );

  // Drive the result word straight from the last normalizer stage
  assign out_o.valid           = n3_vld;
  assign out_o.data.right_x    = n3_side_o.b[0];
  assign out_o.data.right_y    = n3_side_o.b[1];
  assign out_o.data.right_z    = n3_side_o.b[2];
  assign out_o.data.upward_x   = upw[0];
  assign out_o.data.upward_y   = upw[1];
  assign out_o.data.upward_z   = upw[2];
  assign out_o.data.forward_x  = n3_side_o.a[0];
  assign out_o.data.forward_y  = n3_side_o.a[1];
  assign out_o.data.forward_z  = n3_side_o.a[2];
  assign out_o.data.degenerate = n3_side_o.deg;

  // Forward components never exceed one in magnitude
  a_fwd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |->
      out_o.data.forward_x <= lab_pkg::ONE_Q30 && out_o.data.forward_x >= -lab_pkg::ONE_Q30 &&
      out_o.data.forward_y <= lab_pkg::ONE_Q30 && out_o.data.forward_y >= -lab_pkg::ONE_Q30 &&
      out_o.data.forward_z <= lab_pkg::ONE_Q30 && out_o.data.forward_z >= -lab_pkg::ONE_Q30)
    else $error("forward component out of unit range");

  // A clean basis has a non-zero forward and right axis
  a_clean_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.data.degenerate |->
      (out_o.data.forward_x != '0 || out_o.data.forward_y != '0 ||
       out_o.data.forward_z != '0) &&
      (out_o.data.right_x != '0 || out_o.data.right_y != '0 ||
       out_o.data.right_z != '0))
    else $error("zero axis without degenerate flag");

  // A zero forward axis must be flagged
  a_zero_flagged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.forward_x == '0 && out_o.data.forward_y == '0 &&
    out_o.data.forward_z == '0 |-> out_o.data.degenerate)
    else $error("zero forward axis not flagged");

endmodule
`default_nettype wire

// ----- dv/look_at_basis_core_tb.sv -----
// Self-checking testbench for the look-at camera basis core.
`timescale 1ns / 1ps
`default_nettype none
module look_at_basis_core_tb;
  import lab_pkg::*;

  localparam int LATENCY  = 214;
  localparam int WATCHDOG = 20000;
  localparam int N_RANDOM = 1430;

  logic clk_i;
  logic rst_ni;

  lab_in_if  in_ch ();
  lab_out_if out_ch ();

  look_at_basis_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  // Clock: 12 ns period.
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Expected basis words, oldest first.
  out_t basis_q[$];
  int   mismatches;
  int   words_sent;
  int   words_seen;
  int   deg_seen;
  int   idle_cycles;
  bit   sink_hold;
  bit   calm;

  // ---------------------------------------------------------------------------
  // Prediction of the camera basis
  // ---------------------------------------------------------------------------

  // Integer square root, floor.
  function automatic logic [63:0] root_floor(input logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Scale a signed triple so the largest magnitude has its top bit at bit 30.
  // Returns 1 when every component is zero.
  function automatic bit align_vec(input logic signed [63:0] v [3],
                                   output logic signed [63:0] o [3]);
    logic [63:0] m [3];
    logic [63:0] any;
    logic [63:0] t;
    int p;
    for (int i = 0; i < 3; i++) m[i] = v[i] < 0 ? 64'd0 - v[i] : v[i];
    any = m[0] | m[1] | m[2];
    p = -1;
    for (int i = 0; i < 64; i++) if (any[i]) p = i;
    if (p < 0) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b1;
    end
    for (int i = 0; i < 3; i++) begin
      t = p > 30 ? m[i] >> (p - 30) : m[i] << (30 - p);
      o[i] = v[i] < 0 ? -$signed(t) : $signed(t);
    end
    return 1'b0;
  endfunction

  // Unit vector in Q2.30 with rounded division; zero vector stays zero.
  function automatic bit unit_vec(input logic signed [63:0] v [3],
                                  output logic signed [63:0] o [3]);
    logic signed [63:0] s [3];
    logic [63:0] m [3];
    logic [63:0] sum;
    logic [63:0] len;
    logic [63:0] q;
    if (align_vec(v, s)) begin
      for (int i = 0; i < 3; i++) o[i] = 0;
      return 1'b1;
    end
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      m[i] = s[i] < 0 ? 64'd0 - s[i] : s[i];
      sum  = sum + m[i] * m[i];
    end
    len = root_floor(sum);
    for (int i = 0; i < 3; i++) begin
      q    = ((m[i] << 30) + (len >> 1)) / len;
      o[i] = s[i] < 0 ? -$signed(q) : $signed(q);
    end
    return 1'b0;
  endfunction

  function automatic void cross_vec(input logic signed [63:0] a [3],
                                    input logic signed [63:0] b [3],
                                    output logic signed [63:0] c [3]);
    c[0] = a[1] * b[2] - a[2] * b[1];
    c[1] = a[2] * b[0] - a[0] * b[2];
    c[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic out_t camera_basis(input in_t w);
    logic signed [63:0] dir [3];
    logic signed [63:0] upv [3];
    logic signed [63:0] fwd [3];
    logic signed [63:0] ups [3];
    logic signed [63:0] crs [3];
    logic signed [63:0] rgt [3];
    logic signed [63:0] upw [3];
    bit   deg;
    out_t r;
    // Difference is exact in 64 bits for 32-bit coordinates.
    dir[0] = 64'(w.target_x) - 64'(w.eye_x);
    dir[1] = 64'(w.target_y) - 64'(w.eye_y);
    dir[2] = 64'(w.target_z) - 64'(w.eye_z);
    upv[0] = 64'(w.up_x);
    upv[1] = 64'(w.up_y);
    upv[2] = 64'(w.up_z);
    deg = unit_vec(dir, fwd);
    void'(align_vec(upv, ups));
    cross_vec(ups, fwd, crs);
    deg |= unit_vec(crs, rgt);
    cross_vec(fwd, rgt, crs);
    deg |= unit_vec(crs, upw);
    r.right_x    = res_t'(rgt[0]);
    r.right_y    = res_t'(rgt[1]);
    r.right_z    = res_t'(rgt[2]);
    r.upward_x   = res_t'(upw[0]);
    r.upward_y   = res_t'(upw[1]);
    r.upward_z   = res_t'(upw[2]);
    r.forward_x  = res_t'(fwd[0]);
    r.forward_y  = res_t'(fwd[1]);
    r.forward_z  = res_t'(fwd[2]);
    r.degenerate = deg;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: eye, target, up. Rows with a typed-in basis are checked
  // against it as well as the predictor.
  // ---------------------------------------------------------------------------
  typedef struct {
    in_t  word;
    bit   typed;
    out_t basis;
  } row_t;

  localparam coord_t ONE  = 32'sh0001_0000;
  localparam coord_t MAXC = 32'sh7fff_ffff;
  localparam coord_t MINC = 32'sh8000_0000;

  row_t rows[$];

  function automatic in_t mk(input coord_t ex, ey, ez, tx, ty, tz, ux, uy, uz);
    in_t w;
    w = '{ex, ey, ez, tx, ty, tz, ux, uy, uz};
    return w;
  endfunction

  function automatic out_t basis_of(input res_t rx, ry, rz, ux, uy, uz,
                                    fx, fy, fz, input logic d);
    out_t b;
    b = '{rx, ry, rz, ux, uy, uz, fx, fy, fz, d};
    return b;
  endfunction

  task automatic add_row(input in_t w, input bit typed, input out_t b);
    row_t r;
    r.word  = w;
    r.typed = typed;
    r.basis = b;
    rows.push_back(r);
  endtask

  task automatic build_table();
    out_t z;
    z = '0;
    // Eye equals target: everything zero and flagged.
    add_row(mk(0, 0, 0, 0, 0, 0, 0, ONE, 0), 1, basis_of(0,0,0,0,0,0,0,0,0,1));
    add_row(mk(MAXC, MINC, MAXC, MAXC, MINC, MAXC, 0, 0, ONE), 1,
            basis_of(0,0,0,0,0,0,0,0,0,1));
    // Canonical camera: look down +z, up +y.
    add_row(mk(0, 0, 0, 0, 0, ONE, 0, ONE, 0), 1,
            basis_of(ONE_Q30,0,0, 0,ONE_Q30,0, 0,0,ONE_Q30, 0));
    // Up parallel to forward: right and up' zero, flagged.
    add_row(mk(0, 0, 0, 0, 0, ONE, 0, 0, ONE), 1,
            basis_of(0,0,0,0,0,0, 0,0,ONE_Q30, 1));
    // Zero up vector.
    add_row(mk(0, 0, 0, ONE, 0, 0, 0, 0, 0), 1,
            basis_of(0,0,0,0,0,0, ONE_Q30,0,0, 1));
    // Extremes of the coordinate range, widest difference in each sense.
    add_row(mk(MINC, MINC, MINC, MAXC, MAXC, MAXC, 0, ONE, 0), 0, z);
    add_row(mk(MAXC, MAXC, MAXC, MINC, MINC, MINC, MINC, MAXC, 1), 0, z);
    add_row(mk(MINC, 0, 0, MAXC, 0, 0, MAXC, MAXC, MAXC), 0, z);
    add_row(mk(0, MAXC, 0, 0, MINC, 0, MINC, MINC, MINC), 0, z);
    add_row(mk(-1, -1, -1, 0, 0, 0, -1, 0, 0), 0, z);
    // Smallest difference, tiny up vector: heavy left shifts.
    add_row(mk(0, 0, 0, 0, 0, 1, 1, 0, 0), 0, z);
    add_row(mk(0, 0, 0, 1, 1, 1, 0, 1, 0), 0, z);
    // Tiny components lost when scaling shifts right.
    add_row(mk(0, 0, 0, MAXC, 1, 1, 1, MAXC, 0), 0, z);
    add_row(mk(MINC, 0, 0, MAXC, 3, -3, 0, MINC, 2), 0, z);
    // Ordinary cameras with mixed signs.
    add_row(mk(3*ONE, 2*ONE, -5*ONE, -ONE, ONE, 7*ONE, 0, ONE, 0), 0, z);
    add_row(mk(-ONE, -ONE, -ONE, ONE, ONE, ONE, 0, 0, -ONE), 0, z);
    add_row(mk(32'sh1234_5678, 32'sh0abc_def0, -32'sh0fed_cba9,
               32'sh7654_3210, -32'sh2345_6789, 32'sh0000_1111,
               ONE, -ONE, ONE/2), 0, z);
    add_row(mk(MAXC, MAXC, MAXC, MAXC, MAXC, MINC, MINC, 0, 0), 0, z);
  endtask

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------
  function automatic coord_t rand_coord();
    case ($urandom_range(0, 9))
      0:       return coord_t'($urandom_range(0, 3)) - 2;
      1:       return $urandom_range(0, 1) ? MAXC : MINC;
      2:       return coord_t'($signed($urandom_range(0, 255))) - 128;
      3:       return coord_t'($urandom) >>> $urandom_range(0, 30);
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic in_t rand_word();
    in_t w;
    w.eye_x    = rand_coord();
    w.eye_y    = rand_coord();
    w.eye_z    = rand_coord();
    w.target_x = rand_coord();
    w.target_y = rand_coord();
    w.target_z = rand_coord();
    w.up_x     = rand_coord();
    w.up_y     = rand_coord();
    w.up_z     = rand_coord();
    // Now and then make the view collapse or the up vector line up.
    case ($urandom_range(0, 19))
      0: {w.target_x, w.target_y, w.target_z} = {w.eye_x, w.eye_y, w.eye_z};
      1: {w.up_x, w.up_y, w.up_z} = '0;
      2: begin
        w.eye_x = 0; w.eye_y = 0; w.eye_z = 0;
        {w.up_x, w.up_y, w.up_z} = {w.target_x, w.target_y, w.target_z};
      end
      default: ;
    endcase
    return w;
  endfunction

  // Offer one word and hold it until accepted. Drive at the falling edge.
  task automatic send_word(input in_t w);
    if (!calm) begin
      while ($urandom_range(0, 99) < 38) begin
        in_ch.valid <= 1'b0;
        @(negedge clk_i);
      end
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= w;
    basis_q.push_back(camera_basis(w));
    do @(posedge clk_i); while (!in_ch.ready);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (basis_q.size() != 0) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: idle at random, or hold off for a long stretch on request.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (sink_hold) begin
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= 38);
    end
  end

  // Compare each accepted basis word with the oldest expectation.
  out_t exp_basis;
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      words_seen++;
      if (basis_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected basis word %h", out_ch.data);
      end else begin
        exp_basis = basis_q.pop_front();
        if (out_ch.data.degenerate) deg_seen++;
        if (out_ch.data !== exp_basis) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("ERROR: basis word %0d differs", words_seen);
            $display("  right   exp %h %h %h got %h %h %h",
                     exp_basis.right_x, exp_basis.right_y, exp_basis.right_z,
                     out_ch.data.right_x, out_ch.data.right_y, out_ch.data.right_z);
            $display("  upward  exp %h %h %h got %h %h %h",
                     exp_basis.upward_x, exp_basis.upward_y, exp_basis.upward_z,
                     out_ch.data.upward_x, out_ch.data.upward_y,
                     out_ch.data.upward_z);
            $display("  forward exp %h %h %h got %h %h %h",
                     exp_basis.forward_x, exp_basis.forward_y,
                     exp_basis.forward_z, out_ch.data.forward_x,
                     out_ch.data.forward_y, out_ch.data.forward_z);
            $display("  degenerate exp %b got %b",
                     exp_basis.degenerate, out_ch.data.degenerate);
          end
        end
      end
    end
  end

  // Watchdog: count cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG) begin
      $display("ERROR: watchdog expired, %0d basis words outstanding",
               basis_q.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    mismatches  = 0;
    words_sent  = 0;
    words_seen  = 0;
    deg_seen    = 0;
    idle_cycles = 0;
    sink_hold   = 1'b0;
    calm        = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    out_ch.ready = 1'b0;
    rst_ni = 1'b0;
    build_table();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed rows; typed-in rows must also agree with the predictor.
    foreach (rows[i]) begin
      if (rows[i].typed && camera_basis(rows[i].word) !== rows[i].basis) begin
        mismatches++;
        $display("ERROR: predictor disagrees with directed row %0d", i);
      end
      send_word(rows[i].word);
    end
    drain();

    // Random words with phases: back to back, a long receiver stall while
    // the sender keeps offering, and a pause until the pipe empties.
    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == 200) calm = 1'b1;
      if (n == 500) calm = 1'b0;
      if (n == 700) begin
        sink_hold = 1'b1;
        fork
          begin
            repeat (600) @(negedge clk_i);
            sink_hold = 1'b0;
          end
        join_none
      end
      if (n == 1000) drain();
      send_word(rand_word());
    end
    drain();
    repeat (LATENCY + 20) @(negedge clk_i);

    $display("Sent %0d camera queries, checked %0d basis words (%0d degenerate),",
             words_sent, words_seen, deg_seen);
    $display("with random idling on both sides, a long output stall and a drain.");
    if (mismatches == 0 && basis_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches, %0d words missing", mismatches, basis_q.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire
